// File: rtl/lsec_pkg.sv
`timescale 1ns / 1ps

package lsec_pkg;

    // list storage
    localparam int LIST_DEPTH = 64;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
    localparam int RESET_LEN  = (12 > LIST_DEPTH) ? LIST_DEPTH : 12;

    // field widths
    localparam int VAL_W  = 32;
    localparam int TAG_W  = 2;
    localparam int IDX_W  = 6;
    localparam int POS_W  = 6;
    localparam int AMT_W  = 16;
    localparam int CNT_W  = 16;
    localparam int MODE_W = 3;
    localparam int WORD_W = VAL_W + TAG_W;

    // count times shift, signed
    localparam int EFF_W = CNT_W + AMT_W + 1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_STORE      = 3'd0,
        MODE_PASS       = 3'd1,
        MODE_SHIFT_EMIT = 3'd2,
        MODE_SET_SHIFT  = 3'd3,
        MODE_BANG       = 3'd4,
        MODE_CLEAR      = 3'd5,
        MODE_SET_LEN    = 3'd6
    } t_mode;

    typedef struct packed {
        logic accept;
        logic prep;
        logic run;
    } t_cmd;

    typedef struct packed {
        logic       emits;
        logic       issue_last;
        logic [1:0] occ;
    } t_status;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [TAG_W-1:0] tag;
        logic [POS_W-1:0] pos;
        logic             last;
    } t_elem;

endpackage

// File: rtl/lsec_ram.sv
`timescale 1ns / 1ps

module lsec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lsec_ctrl.sv
`timescale 1ns / 1ps

module lsec_ctrl
    import lsec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_st,
    output t_cmd    o_cmd,
    output logic    o_stall
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid && i_st.emits) begin
                        r_state <= ST_PREP;
                        r_busy  <= 1'b1;
                    end
                end
                ST_PREP: begin
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (i_st.issue_last) begin
                        r_state <= ST_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.accept = (r_state == ST_IDLE) && i_valid;
        o_cmd.prep   = (r_state == ST_PREP);
        o_cmd.run    = (r_state == ST_RUN);
    end

    assign o_stall = r_busy;

endmodule

// File: rtl/lsec_dp.sv
`timescale 1ns / 1ps

module lsec_dp
    import lsec_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [VAL_W-1:0]        i_elem_value,
    input  logic [TAG_W-1:0]        i_elem_tag,
    input  logic [IDX_W-1:0]        i_elem_index,
    input  logic                    i_elem_last,
    input  logic signed [AMT_W-1:0] i_amount,
    input  t_cmd                    i_cmd,
    output t_status                 o_st,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic [VAL_W-1:0]        o_out_value,
    output logic [TAG_W-1:0]        o_out_tag,
    output logic [POS_W-1:0]        o_out_position,
    output logic                    o_out_last
);

    // list state
    logic [LIST_DEPTH-1:0]   r_valid;
    logic [LEN_W-1:0]        r_length;
    logic signed [AMT_W-1:0] r_shift;
    logic [CNT_W-1:0]        r_count;

    // emission setup
    logic [LEN_W-1:0]        r_emit_len;
    logic                    r_emit_scr;
    logic                    r_mult_sel;
    logic signed [EFF_W-1:0] r_eff;
    logic [ADDR_W-1:0]       r_i;

    // read pipeline
    logic              r_infl;
    logic [POS_W-1:0]  r_p_pos;
    logic              r_p_last;
    logic              r_p_scr;
    logic              r_p_vbit;
    logic              r_p_zero;

    // output buffer
    t_elem r_head;
    t_elem r_skid;
    logic  r_head_vld;
    logic  r_skid_vld;

    t_mode                   mode;
    logic                    idx_ok;
    logic [IDX_W:0]          n_wide;
    logic [LEN_W-1:0]        n_len;
    logic [LEN_W-1:0]        set_len;
    int                      amt_i;
    logic signed [EFF_W-1:0] prod;
    logic signed [EFF_W:0]   diff;
    logic [ADDR_W-1:0]       last_idx;
    logic [ADDR_W-1:0]       src;
    logic                    issue;
    logic                    issue_ok;
    logic                    pop;
    logic [1:0]              occ;
    logic                    we_sto;
    logic                    we_scr;
    logic [ADDR_W-1:0]       waddr;
    logic [WORD_W-1:0]       sto_rd;
    logic [WORD_W-1:0]       scr_rd;
    t_elem                   arr;

    assign mode   = t_mode'(i_mode);
    assign idx_ok = ({{(32-IDX_W){1'b0}}, i_elem_index} < 32'(LIST_DEPTH));
    assign n_wide = {1'b0, i_elem_index} + {{IDX_W{1'b0}}, 1'b1};
    assign waddr  = ADDR_W'(i_elem_index);

    always_comb begin
        if ({{(31-IDX_W){1'b0}}, n_wide} > 32'(LIST_DEPTH)) begin
            n_len = LEN_W'(LIST_DEPTH);
        end else begin
            n_len = LEN_W'(n_wide);
        end
    end

    always_comb begin
        amt_i = int'(i_amount);
        if (amt_i < 1) begin
            set_len = LEN_W'(1);
        end else if (amt_i > LIST_DEPTH) begin
            set_len = LEN_W'(LIST_DEPTH);
        end else begin
            set_len = LEN_W'(amt_i);
        end
    end

    assign o_st.emits = ((mode == MODE_PASS) && i_elem_last)
                        || (mode == MODE_SHIFT_EMIT) || (mode == MODE_BANG);

    assign we_sto = i_cmd.accept && (mode == MODE_STORE) && idx_ok;
    assign we_scr = i_cmd.accept && (mode == MODE_PASS) && idx_ok;

    // list state updates on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_length <= LEN_W'(RESET_LEN);
            r_shift  <= AMT_W'(1);
            r_count  <= '0;
        end else if (i_cmd.accept) begin
            case (mode)
                MODE_STORE: begin
                    if (idx_ok) begin
                        r_valid[waddr] <= 1'b1;
                    end
                    if (i_elem_last) begin
                        for (int k = 0; k < LIST_DEPTH; k++) begin
                            if (k >= int'(n_len)) begin
                                r_valid[k] <= 1'b0;
                            end
                        end
                        r_length <= n_len;
                        r_count  <= '0;
                    end
                end
                MODE_SHIFT_EMIT: begin
                    r_shift <= i_amount;
                    r_count <= CNT_W'(1);
                end
                MODE_SET_SHIFT: begin
                    r_shift <= i_amount;
                    r_count <= '0;
                end
                MODE_BANG: begin
                    if ((r_shift != '0) && (r_count != CNT_MAX)) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                MODE_CLEAR: begin
                    r_valid  <= '0;
                    r_length <= LEN_W'(RESET_LEN);
                    r_shift  <= '0;
                    r_count  <= '0;
                end
                MODE_SET_LEN: begin
                    r_length <= set_len;
                end
                default: begin
                end
            endcase
        end
    end

    // emission setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_emit_scr <= (mode == MODE_PASS);
            r_mult_sel <= (mode == MODE_BANG);
            if (mode == MODE_PASS) begin
                r_emit_len <= n_len;
            end else begin
                r_emit_len <= r_length;
            end
        end
    end

    assign prod = $signed({1'b0, r_count}) * r_shift;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_eff <= r_mult_sel ? prod : EFF_W'(r_shift);
            r_i   <= '0;
        end else if (issue) begin
            r_i <= r_i + ADDR_W'(1);
        end
    end

    // source index: clamp(i - shift, 0, len - 1)
    assign last_idx = ADDR_W'(r_emit_len - LEN_W'(1));
    assign diff = $signed({{(EFF_W+1-ADDR_W){1'b0}}, r_i})
                  - $signed({r_eff[EFF_W-1], r_eff});

    always_comb begin
        if (diff[EFF_W]) begin
            src = '0;
        end else if (diff[EFF_W-1:0] >= EFF_W'(r_emit_len)) begin
            src = last_idx;
        end else begin
            src = diff[ADDR_W-1:0];
        end
    end

    // buffer credit: head + skid + read in flight
    assign pop = r_head_vld && !i_stall;
    assign occ = {1'b0, r_head_vld} + {1'b0, r_skid_vld} + {1'b0, r_infl};
    assign issue_ok = (occ < 2'd2) || (pop && (occ == 2'd2));
    assign issue = i_cmd.run && issue_ok;

    assign o_st.issue_last = issue && (r_i == last_idx);
    assign o_st.occ        = occ;

    lsec_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LIST_DEPTH)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (we_sto),
        .i_waddr (waddr),
        .i_wdata ({i_elem_value, i_elem_tag}),
        .i_re    (issue),
        .i_raddr (src),
        .o_rdata (sto_rd)
    );

    lsec_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LIST_DEPTH)
    ) u_scratch_ram (
        .i_clk   (i_clk),
        .i_we    (we_scr),
        .i_waddr (waddr),
        .i_wdata ({i_elem_value, i_elem_tag}),
        .i_re    (issue),
        .i_raddr (src),
        .o_rdata (scr_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_infl <= 1'b0;
        end else begin
            r_infl <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_p_pos  <= POS_W'(r_i);
            r_p_last <= (r_i == last_idx);
            r_p_scr  <= r_emit_scr;
            r_p_vbit <= r_valid[src];
            r_p_zero <= (src == '0);
        end
    end

    // never written stored entries read as their reset value
    always_comb begin
        if (r_p_scr) begin
            arr.value = scr_rd[WORD_W-1:TAG_W];
            arr.tag   = scr_rd[TAG_W-1:0];
        end else if (r_p_vbit) begin
            arr.value = sto_rd[WORD_W-1:TAG_W];
            arr.tag   = sto_rd[TAG_W-1:0];
        end else begin
            arr.value = r_p_zero ? VAL_W'(1) : '0;
            arr.tag   = '0;
        end
        arr.pos  = r_p_pos;
        arr.last = r_p_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (!r_head_vld || pop) begin
                if (r_skid_vld) begin
                    r_head_vld <= 1'b1;
                    r_skid_vld <= r_infl;
                end else begin
                    r_head_vld <= r_infl;
                end
            end else if (r_infl) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_head_vld || pop) begin
            if (r_skid_vld) begin
                r_head <= r_skid;
                if (r_infl) begin
                    r_skid <= arr;
                end
            end else if (r_infl) begin
                r_head <= arr;
            end
        end else if (r_infl) begin
            r_skid <= arr;
        end
    end

    assign o_valid        = r_head_vld;
    assign o_out_value    = r_head.value;
    assign o_out_tag      = r_head.tag;
    assign o_out_position = r_head.pos;
    assign o_out_last     = r_head.last;

endmodule

// File: rtl/list_shift_edge_clamp_core.sv
`timescale 1ns / 1ps
// list shifter with edge replication
// input channel (i_valid / o_stall): one command transaction per item; i_mode
//   selects store element, pass element, shift and emit, set shift, bang,
//   clear or set length. commands without results do not raise o_stall.
// output channel (o_valid / i_stall): one transaction per emitted element,
//   o_out_position counting up from 0 and o_out_last on the final one.
// an emitting command holds o_stall through the prep state, which forms
//   count * shift in the multiplier for a bang, and the run state, which
//   issues one list read per entry to the read port of both list rams.
//   the first element passes the prep state, the run state and the ram read
//   register on its way to the output register; without backpressure the
//   list then streams one element per cycle, up to 64 per command.
// a two-entry output buffer (output register plus skid) absorbs a stalled
//   receiver; reads are issued only while the buffer has room, so i_stall
//   slows the read walk and nothing is dropped.
// the next command is taken as soon as the last read is issued, while the
//   tail of the list may still wait in the output buffer.
// reset (synchronous, active low) empties the buffer and restores the
//   default list (first entry 1, rest 0), length 12, shift 1, count 0;
//   no clearing pass is needed since per-entry valid bits cover the list.

module list_shift_edge_clamp_core
    import lsec_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [VAL_W-1:0]        i_elem_value,
    input  logic [TAG_W-1:0]        i_elem_tag,
    input  logic [IDX_W-1:0]        i_elem_index,
    input  logic                    i_elem_last,
    input  logic signed [AMT_W-1:0] i_amount,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [VAL_W-1:0]        o_out_value,
    output logic [TAG_W-1:0]        o_out_tag,
    output logic [POS_W-1:0]        o_out_position,
    output logic                    o_out_last
);

    // command from controller, status back from datapath
    t_cmd    cmd;
    t_status st;

    lsec_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    // list state, list rams, read walk and output buffer
    lsec_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (i_mode),
        .i_elem_value   (i_elem_value),
        .i_elem_tag     (i_elem_tag),
        .i_elem_index   (i_elem_index),
        .i_elem_last    (i_elem_last),
        .i_amount       (i_amount),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_value    (o_out_value),
        .o_out_tag      (o_out_tag),
        .o_out_position (o_out_position),
        .o_out_last     (o_out_last)
    );

`ifndef ASSERT_OFF
    // an emitting transaction locks the input side
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && st.emits) |=> o_stall)
        else $error("emitting command did not raise stall");

    // the final read frees the input side on the next cycle
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.issue_last |=> !o_stall)
        else $error("stall held after final read");

    // buffer plus read in flight never exceeds two entries
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.occ != 2'd3)
        else $error("output buffer overrun");
`endif

endmodule

// File: sim/list_shift_edge_clamp_core_tb.sv
`timescale 1ns / 1ps

module list_shift_edge_clamp_core_tb;
    import lsec_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 345;

    typedef struct {
        logic [MODE_W-1:0]       mode;
        logic [VAL_W-1:0]        value;
        logic [TAG_W-1:0]        tag;
        logic [IDX_W-1:0]        index;
        logic                    last;
        logic signed [AMT_W-1:0] amount;
        bit                      drain;   // wait for all results before offering
    } t_list_cmd;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [MODE_W-1:0]       i_mode = '0;
    logic [VAL_W-1:0]        i_elem_value = '0;
    logic [TAG_W-1:0]        i_elem_tag = '0;
    logic [IDX_W-1:0]        i_elem_index = '0;
    logic                    i_elem_last = 1'b0;
    logic signed [AMT_W-1:0] i_amount = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [VAL_W-1:0]        o_out_value;
    logic [TAG_W-1:0]        o_out_tag;
    logic [POS_W-1:0]        o_out_position;
    logic                    o_out_last;

    list_shift_edge_clamp_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_elem_value   (i_elem_value),
        .i_elem_tag     (i_elem_tag),
        .i_elem_index   (i_elem_index),
        .i_elem_last    (i_elem_last),
        .i_amount       (i_amount),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_value    (o_out_value),
        .o_out_tag      (o_out_tag),
        .o_out_position (o_out_position),
        .o_out_last     (o_out_last)
    );

    // shadow of the block's list state
    logic [VAL_W-1:0]        kept_vals [LIST_DEPTH];
    logic [TAG_W-1:0]        kept_tags [LIST_DEPTH];
    logic [VAL_W-1:0]        pass_vals [LIST_DEPTH];
    logic [TAG_W-1:0]        pass_tags [LIST_DEPTH];
    int                      kept_len;
    logic signed [AMT_W-1:0] step_size;
    int                      bang_count;

    t_list_cmd pending_cmds[$];
    t_elem     expected_elems[$];
    t_list_cmd cur_cmd;

    int  total_cmds = 0;
    int  cmds_taken = 0;
    int  elems_seen = 0;
    int  errors = 0;
    int  idle_cycles = 0;
    int  drained_cycles = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    // generator side: scratch entries written so far, so no pass list reads an unwritten one
    bit [LIST_DEPTH-1:0] pass_written = '0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 8);
        if (r < 97) return $urandom_range(9, 20);
        return $urandom_range(33, LIST_DEPTH);
    endfunction

    // shift near the list length most of the time, any 16-bit value otherwise
    function automatic logic [AMT_W-1:0] pick_amount(input int len);
        int v;
        if ($urandom_range(0, 99) < 80) begin
            v = $urandom_range(0, 2 * len + 4) - (len + 2);
        end else begin
            v = $urandom;
        end
        return v[AMT_W-1:0];
    endfunction

    task automatic add_cmd(input logic [MODE_W-1:0] mode, input logic [VAL_W-1:0] value,
                           input logic [TAG_W-1:0] tag, input logic [IDX_W-1:0] index,
                           input logic last, input logic [AMT_W-1:0] amount,
                           input bit drain);
        t_list_cmd c;
        c.mode   = mode;
        c.value  = value;
        c.tag    = tag;
        c.index  = index;
        c.last   = last;
        c.amount = amount;
        c.drain  = drain;
        if (mode == MODE_PASS) pass_written[index] = 1'b1;
        pending_cmds.push_back(c);
        total_cmds++;
    endtask

    task automatic restore_kept();
        int k;
        for (k = 0; k < LIST_DEPTH; k++) begin
            kept_vals[k] = '0;
            kept_tags[k] = '0;
        end
        kept_vals[0] = 1;
        kept_len = RESET_LEN;
    endtask

    // expected elements of one emitted list, edges replicated
    task automatic emit_list(input bit from_pass, input int len, input longint shift);
        int     n;
        int     i;
        longint src;
        t_elem  e;
        n = (len < 1) ? 1 : ((len > LIST_DEPTH) ? LIST_DEPTH : len);
        for (i = 0; i < n; i++) begin
            src = longint'(i) - shift;
            if (src >= n) src = n - 1;
            if (src < 0) src = 0;
            e.value = from_pass ? pass_vals[src[ADDR_W-1:0]] : kept_vals[src[ADDR_W-1:0]];
            e.tag   = from_pass ? pass_tags[src[ADDR_W-1:0]] : kept_tags[src[ADDR_W-1:0]];
            e.pos   = i[POS_W-1:0];
            e.last  = (i == n - 1);
            expected_elems.push_back(e);
        end
    endtask

    // driver: offers queued commands, predicts on each accepted one
    always @(posedge i_clk) begin : driver
        int  k;
        bit  send_quiet;
        send_quiet = ((cmds_taken / 40) % 4) == 3;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                case (cur_cmd.mode)
                    MODE_STORE: begin
                        kept_vals[cur_cmd.index] = cur_cmd.value;
                        kept_tags[cur_cmd.index] = cur_cmd.tag;
                        if (cur_cmd.last) begin
                            for (k = int'(cur_cmd.index) + 1; k < LIST_DEPTH; k++) begin
                                kept_vals[k] = '0;
                                kept_tags[k] = '0;
                            end
                            kept_len = int'(cur_cmd.index) + 1;
                            bang_count = 0;
                        end
                    end
                    MODE_PASS: begin
                        pass_vals[cur_cmd.index] = cur_cmd.value;
                        pass_tags[cur_cmd.index] = cur_cmd.tag;
                        if (cur_cmd.last)
                            emit_list(1'b1, int'(cur_cmd.index) + 1, longint'(step_size));
                    end
                    MODE_SHIFT_EMIT: begin
                        step_size = cur_cmd.amount;
                        bang_count = 1;
                        emit_list(1'b0, kept_len, longint'(cur_cmd.amount));
                    end
                    MODE_SET_SHIFT: begin
                        step_size = cur_cmd.amount;
                        bang_count = 0;
                    end
                    MODE_BANG: begin
                        if (step_size != 0 && bang_count < int'(CNT_MAX)) bang_count++;
                        emit_list(1'b0, kept_len, longint'(bang_count) * longint'(step_size));
                    end
                    MODE_CLEAR: begin
                        restore_kept();
                        step_size = 0;
                        bang_count = 0;
                    end
                    MODE_SET_LEN: begin
                        if (cur_cmd.amount < 1) kept_len = 1;
                        else if (cur_cmd.amount > LIST_DEPTH) kept_len = LIST_DEPTH;
                        else kept_len = int'(cur_cmd.amount);
                    end
                    default: ;
                endcase
                cmds_taken++;
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    i_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_cmds.size() == 0 ||
                             (pending_cmds[0].drain &&
                              (expected_elems.size() != 0 || drained_cycles < 8))) begin
                    i_valid <= 1'b0;
                end else begin
                    cur_cmd = pending_cmds.pop_front();
                    i_mode       <= cur_cmd.mode;
                    i_elem_value <= cur_cmd.value;
                    i_elem_tag   <= cur_cmd.tag;
                    i_elem_index <= cur_cmd.index;
                    i_elem_last  <= cur_cmd.last;
                    i_amount     <= cur_cmd.amount;
                    i_valid      <= 1'b1;
                    gap_left     <= send_quiet ? 0 : pick_gap();
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off so the block backs up
    always @(posedge i_clk) begin : receiver
        bit recv_quiet;
        recv_quiet = ((elems_seen / 90) % 4) == 2;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && elems_seen >= 150) begin
            i_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!recv_quiet && $urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            stall_left <= pick_gap();
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor: each element against the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_elem want;
        if (i_rst_n && o_valid && !i_stall) begin
            elems_seen++;
            if (expected_elems.size() == 0) begin
                $display("%0t unexpected element: value %h tag %0d position %0d last %0d",
                         $time, o_out_value, o_out_tag, o_out_position, o_out_last);
                errors++;
            end else begin
                want = expected_elems.pop_front();
                if (o_out_value !== want.value) begin
                    $display("%0t value: expected %h, got %h", $time, want.value, o_out_value);
                    errors++;
                end
                if (o_out_tag !== want.tag) begin
                    $display("%0t tag: expected %0d, got %0d", $time, want.tag, o_out_tag);
                    errors++;
                end
                if (o_out_position !== want.pos) begin
                    $display("%0t position: expected %0d, got %0d",
                             $time, want.pos, o_out_position);
                    errors++;
                end
                if (o_out_last !== want.last) begin
                    $display("%0t last: expected %0d, got %0d", $time, want.last, o_out_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (expected_elems.size() == 0) drained_cycles <= drained_cycles + 1;
        else drained_cycles <= 0;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("list_shift_edge_clamp_core_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        int rand_count;
        int r;
        int n;
        int i;
        int j;
        bit drain_next;

        restore_kept();
        step_size = 1;
        bang_count = 0;
        for (i = 0; i < LIST_DEPTH; i++) begin
            pass_vals[i] = '0;
            pass_tags[i] = '0;
        end

        // directed: reset list, extreme shifts and lengths, edge clamping
        add_cmd(MODE_BANG, $urandom, 2'd0, 6'd0, 1'b0, 16'h0000, 1'b0);
        add_cmd(MODE_BANG, $urandom, 2'd1, 6'd63, 1'b1, 16'hffff, 1'b0);
        add_cmd(MODE_SHIFT_EMIT, $urandom, 2'd2, 6'd0, 1'b0, 16'h0000, 1'b0);
        add_cmd(MODE_SHIFT_EMIT, $urandom, 2'd0, 6'd0, 1'b0, 16'h7fff, 1'b0);
        add_cmd(MODE_SHIFT_EMIT, $urandom, 2'd0, 6'd0, 1'b0, 16'h8000, 1'b0);
        add_cmd(MODE_SET_SHIFT, $urandom, 2'd0, 6'd0, 1'b0, 16'hfffd, 1'b0);
        add_cmd(MODE_BANG, $urandom, 2'd0, 6'd0, 1'b0, 16'h0000, 1'b0);
        // length below one, then saturation at depth
        add_cmd(MODE_SET_LEN, $urandom, 2'd0, 6'd0, 1'b0, 16'h0000, 1'b0);
        add_cmd(MODE_BANG, $urandom, 2'd0, 6'd0, 1'b0, 16'h0000, 1'b0);
        add_cmd(MODE_SET_LEN, $urandom, 2'd0, 6'd0, 1'b0, 16'h8000, 1'b0);
        add_cmd(MODE_SET_LEN, $urandom, 2'd0, 6'd0, 1'b0, 16'h7fff, 1'b0);
        add_cmd(MODE_SHIFT_EMIT, $urandom, 2'd0, 6'd0, 1'b0, 16'd5, 1'b0);
        add_cmd(MODE_SET_LEN, $urandom, 2'd0, 6'd0, 1'b0, 16'd65, 1'b0);
        // short stored list, tail cleared by the last mark
        add_cmd(MODE_STORE, 32'hffffffff, 2'd2, 6'd0, 1'b0, 16'h5555, 1'b0);
        add_cmd(MODE_STORE, 32'h00000000, 2'd1, 6'd63, 1'b0, 16'haaaa, 1'b0);
        add_cmd(MODE_STORE, 32'ha5a5a5a5, 2'd2, 6'd2, 1'b1, 16'h0000, 1'b0);
        add_cmd(MODE_SHIFT_EMIT, $urandom, 2'd0, 6'd0, 1'b0, 16'hffff, 1'b0);
        // unused mode leaves everything alone
        add_cmd(MODE_UNUSED, $urandom, 2'd2, 6'd63, 1'b1, 16'h8000, 1'b0);
        // pass list of four, shifted by the stored shift
        add_cmd(MODE_PASS, 32'h00000000, 2'd0, 6'd0, 1'b0, AMT_W'($urandom), 1'b0);
        add_cmd(MODE_PASS, 32'hffffffff, 2'd1, 6'd1, 1'b0, AMT_W'($urandom), 1'b0);
        add_cmd(MODE_PASS, 32'h5a5a5a5a, 2'd2, 6'd2, 1'b0, AMT_W'($urandom), 1'b0);
        add_cmd(MODE_PASS, 32'h00000001, 2'd0, 6'd3, 1'b1, AMT_W'($urandom), 1'b0);
        // clear gives shift zero, so a bang does not advance the count
        add_cmd(MODE_CLEAR, $urandom, 2'd0, 6'd0, 1'b0, AMT_W'($urandom), 1'b1);
        add_cmd(MODE_BANG, $urandom, 2'd0, 6'd0, 1'b0, AMT_W'($urandom), 1'b0);
        add_cmd(MODE_BANG, $urandom, 2'd0, 6'd0, 1'b0, AMT_W'($urandom), 1'b0);

        // random: mostly whole lists and emits, some noise
        rand_count = 0;
        drain_next = 1'b1;
        while (rand_count < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 18) begin
                n = pick_len();
                for (i = 0; i < n; i++) begin
                    if (i == n - 1 || $urandom_range(0, 7) != 0) begin
                        add_cmd(MODE_STORE, $urandom, TAG_W'($urandom_range(0, 2)),
                                i[IDX_W-1:0], i == n - 1, AMT_W'($urandom), drain_next);
                        drain_next = 1'b0;
                        rand_count++;
                    end
                end
            end else if (r < 38) begin
                n = pick_len();
                for (i = 0; i < n; i++) begin
                    if (i == n - 1 || !pass_written[i] || $urandom_range(0, 3) != 0) begin
                        add_cmd(MODE_PASS, $urandom, TAG_W'($urandom_range(0, 2)),
                                i[IDX_W-1:0], i == n - 1, AMT_W'($urandom), drain_next);
                        drain_next = 1'b0;
                        rand_count++;
                    end
                end
            end else if (r < 52) begin
                add_cmd(MODE_SHIFT_EMIT, $urandom, TAG_W'($urandom_range(0, 2)),
                        IDX_W'($urandom), 1'($urandom), pick_amount(kept_len), drain_next);
                drain_next = 1'b0;
                rand_count++;
            end else if (r < 60) begin
                add_cmd(MODE_SET_SHIFT, $urandom, TAG_W'($urandom_range(0, 2)),
                        IDX_W'($urandom), 1'($urandom), pick_amount(4), drain_next);
                drain_next = 1'b0;
                rand_count++;
                j = $urandom_range(1, 5);
                for (i = 0; i < j; i++) begin
                    add_cmd(MODE_BANG, $urandom, TAG_W'($urandom_range(0, 2)),
                            IDX_W'($urandom), 1'($urandom), AMT_W'($urandom), 1'b0);
                    rand_count++;
                end
            end else if (r < 72) begin
                add_cmd(MODE_BANG, $urandom, TAG_W'($urandom_range(0, 2)),
                        IDX_W'($urandom), 1'($urandom), AMT_W'($urandom), drain_next);
                drain_next = 1'b0;
                rand_count++;
            end else if (r < 75) begin
                add_cmd(MODE_CLEAR, $urandom, TAG_W'($urandom_range(0, 2)),
                        IDX_W'($urandom), 1'($urandom), AMT_W'($urandom), drain_next);
                drain_next = 1'b0;
                rand_count++;
            end else if (r < 85) begin
                if ($urandom_range(0, 3) == 0) j = $urandom;
                else j = $urandom_range(0, 20);
                add_cmd(MODE_SET_LEN, $urandom, TAG_W'($urandom_range(0, 2)),
                        IDX_W'($urandom), 1'($urandom), j[AMT_W-1:0], drain_next);
                drain_next = 1'b0;
                rand_count++;
            end else begin
                j = $urandom_range(0, 2);
                if (j == 0) begin
                    add_cmd(MODE_UNUSED, $urandom, TAG_W'($urandom_range(0, 2)),
                            IDX_W'($urandom), 1'($urandom), AMT_W'($urandom), drain_next);
                end else begin
                    // stray element writes without a last mark
                    add_cmd((j == 1) ? MODE_PASS : MODE_STORE, $urandom,
                            TAG_W'($urandom_range(0, 2)), IDX_W'($urandom), 1'b0,
                            AMT_W'($urandom), drain_next);
                    rand_count++;
                end
                drain_next = 1'b0;
            end
            if ($urandom_range(0, 59) == 0) drain_next = 1'b1;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_taken != total_cmds) @(posedge i_clk);
        while (expected_elems.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (errors == 0 && expected_elems.size() == 0) begin
            $display("list_shift_edge_clamp_core_tb: done, clean");
        end else begin
            $display("list_shift_edge_clamp_core_tb: done, errors");
        end
        $finish;
    end

endmodule
